/* design/htw_pkg.sv */
// ----------------------------------------------------------------------------
// htw_pkg: shared types and constants for the Huffman tree-walk decoder
// Beat formats, node table entry, queue command and engine state encoding.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int IDX_W     = 9;   // node index width
  localparam int SYM_W     = 8;   // symbol width
  localparam int BYTE_W    = 8;   // compressed byte width
  localparam int TOP_BIT   = 7;   // index of first bit consumed in a byte
  localparam int BITCNT_W  = 3;   // counts bits of one byte
  localparam int QDEPTH    = 2;   // command queue depth
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  // Input beat
  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  node_index;
    logic [IDX_W-1:0]  left_child;
    logic [IDX_W-1:0]  right_child;
    logic              is_leaf;
    logic [SYM_W-1:0]  leaf_symbol;
    logic [BYTE_W-1:0] code_byte;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             error;
  } out_t;

  // One node table entry
  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    logic [SYM_W-1:0] symbol;
  } node_t;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  // Classified command held in the queue
  typedef struct packed {
    cmd_e              kind;
    logic [IDX_W-1:0]  node_index;
    node_t             node;
    logic [BYTE_W-1:0] code_byte;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_BIT,
    ST_TAIL,
    ST_FLUSH
  } back_state_e;

  // Engine status seen by the top level
  typedef struct packed {
    logic busy;
    logic pend_valid;
  } htw_status_t;

endpackage

/* design/htw_front.sv */
// ----------------------------------------------------------------------------
// htw_front: input acceptance, classification and command queue
// Turns input beats into load/decode commands and buffers them.
// ----------------------------------------------------------------------------
module htw_front import htw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_data_i,
  output logic  cmd_valid_o,
  input  logic  cmd_ready_i,
  output cmd_t  cmd_o
);

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  cmd_t              cmd_new;
  logic              push, pop;

  assign in_ready_o  = (cnt_q != QCNT_W'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cmd_new.kind        = in_data_i.req_type ? CMD_DECODE : CMD_LOAD;
    cmd_new.node_index  = in_data_i.node_index;
    cmd_new.node.left   = in_data_i.left_child;
    cmd_new.node.right  = in_data_i.right_child;
    cmd_new.node.leaf   = in_data_i.is_leaf;
    cmd_new.node.symbol = in_data_i.leaf_symbol;
    cmd_new.code_byte   = in_data_i.code_byte;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* design/htw_back.sv */
// ----------------------------------------------------------------------------
// htw_back: node table and tree-walk engine
// Executes queued loads and decodes; one tree step per cycle while output has room.
// ----------------------------------------------------------------------------
module htw_back import htw_pkg::*; #(
  parameter int NODE_COUNT = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  cmd_t             cmd_i,
  input  logic [IDX_W-1:0] root_i,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  output htw_status_t      status_o
);

  localparam int             AW       = $clog2(NODE_COUNT);
  localparam logic [IDX_W:0] NODE_LIM = (IDX_W+1)'(NODE_COUNT);
  localparam logic [BITCNT_W-1:0] LAST_BIT = BITCNT_W'(TOP_BIT);

  node_t mem [NODE_COUNT];

  back_state_e        state_q, state_d;
  logic [IDX_W-1:0]   walk_q, walk_d;
  node_t              root_ent_q, root_ent_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic [BITCNT_W-1:0] cnt_q, cnt_d;
  logic               pend_v_q, pend_v_d;
  logic [SYM_W-1:0]   pend_sym_q, pend_sym_d;
  logic [IDX_W-1:0]   rd_addr_q;
  logic               oob_q;
  node_t              rd_data_q;
  logic               out_v_q;
  out_t               out_q;

  node_t              ent, cur;
  logic               hit, push_v, out_space, adv;
  out_t               push_d;
  logic               rd_en, mem_we;
  logic [IDX_W-1:0]   rd_addr;

  assign ent       = oob_q ? '0 : rd_data_q;  // beyond the table reads as zero
  assign out_space = !out_v_q || out_ready_i;
  assign adv       = !push_v || out_space;

  // Leaf detection and result requests
  always_comb begin
    hit    = 1'b0;
    push_v = 1'b0;
    push_d = '0;
    case (state_q)
      ST_POS: begin
        push_v       = ent.leaf;
        push_d.last  = 1'b1;
        push_d.error = 1'b1;
      end
      ST_BIT: begin
        hit    = (cnt_q != '0) && ent.leaf;
        push_v = hit && pend_v_q;
        push_d.symbol = pend_sym_q;
      end
      ST_TAIL: begin
        hit    = ent.leaf;
        push_v = hit && pend_v_q;
        push_d.symbol = pend_sym_q;
      end
      ST_FLUSH: begin
        push_v        = pend_v_q;
        push_d.symbol = pend_sym_q;
        push_d.last   = 1'b1;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.kind == CMD_DECODE)) begin
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        if (adv) begin
          state_d = ent.leaf ? ST_IDLE : ST_BIT;
        end
      end
      ST_BIT: begin
        if (adv && (cnt_q == LAST_BIT)) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (adv) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath controls and register updates
  always_comb begin
    cur         = ent;
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = root_i;
    walk_d      = walk_q;
    root_ent_d  = root_ent_q;
    byte_d      = byte_q;
    cnt_d       = cnt_q;
    pend_v_d    = pend_v_q;
    pend_sym_d  = pend_sym_q;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (cmd_i.kind == CMD_LOAD) begin
            mem_we = ({1'b0, cmd_i.node_index} < NODE_LIM);
          end else begin
            rd_en  = 1'b1;
            byte_d = cmd_i.code_byte;
          end
        end
      end
      ST_POS: begin
        if (ent.leaf) begin
          if (adv) begin
            walk_d = root_i;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = walk_q;
          root_ent_d = ent;
          cnt_d      = '0;
        end
      end
      ST_BIT: begin
        cur     = hit ? root_ent_q : ent;
        rd_addr = byte_q[BYTE_W-1] ? cur.right : cur.left;
        if (adv) begin
          rd_en  = 1'b1;
          byte_d = {byte_q[BYTE_W-2:0], 1'b0};
          cnt_d  = cnt_q + 1'b1;
          if (hit) begin
            pend_v_d   = 1'b1;
            pend_sym_d = ent.symbol;
          end
        end
      end
      ST_TAIL: begin
        if (adv) begin
          if (hit) begin
            pend_v_d   = 1'b1;
            pend_sym_d = ent.symbol;
            walk_d     = root_i;
          end else begin
            walk_d = rd_addr_q;   // partial code carries to the next byte
          end
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          pend_v_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Node table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_i.node_index[AW-1:0]] <= cmd_i.node;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    root_ent_q <= root_ent_d;
    byte_q     <= byte_d;
    cnt_q      <= cnt_d;
    pend_sym_q <= pend_sym_d;
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (push_v && out_space) begin
      out_q <= push_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      walk_q   <= '0;
      pend_v_q <= 1'b0;
      oob_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
      walk_q   <= cfg_we_i ? cfg_data_i : walk_d;
      if (rd_en) begin
        oob_q <= !({1'b0, rd_addr} < NODE_LIM);
      end
      if (push_v && out_space) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_v_q;
  assign out_data_o          = out_q;
  assign status_o.busy       = (state_q != ST_IDLE);
  assign status_o.pend_valid = pend_v_q;

endmodule

/* design/huffman_tree_walk_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder: Huffman decoder walking a stored code tree
// Engine: a decode beat goes through root check, node fetch, 8 dependent
//   node-table reads and 2 wrap-up steps, set by the single read port of the
//   node table; a leaf at the root gives an error beat after the check.
//   The engine takes no new command until it is back in idle, and output
//   back-pressure can stall it; a load beat is executed while it is idle.
// Reset: root and walk position go to node 0; the node table is not cleared.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder import htw_pkg::*; #(
  parameter int NODE_COUNT = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input beats: node loads and compressed bytes
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  // decoded symbols
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  // root register write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_data_i
);

  // Root register. A write also restarts the walk at the new root, which
  // the engine handles through cfg_we.
  logic [IDX_W-1:0] root_q;
  logic             cfg_we;

  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;
  htw_status_t status;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we) begin
      root_q <= cfg_data_i;
    end
  end

  // Front end: accepts beats, tags them load or decode, queues two deep
  htw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Back end: node table, walk engine, output register.
  // A symbol is held back until the next one or the end of its byte, so the last one of a byte can be flagged.
  htw_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .root_i      (root_q),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .status_o    (status)
  );

  // A held symbol never outlives the byte that produced it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.busy |-> !status.pend_valid)
    else $error("pending symbol left behind after decode");

  // An error beat is a lone, last beat with a zero symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error) |-> (out_data_o.last && (out_data_o.symbol == '0)))
    else $error("malformed error beat");

  // The engine only takes commands while idle; a decode makes it busy, a load leaves it idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |=> (status.busy == $past(cmd.kind == CMD_DECODE)))
    else $error("engine state does not follow command kind");

endmodule

/* tb/tb_huffman_tree_walk_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_walk_decoder: self-checking bench for the tree-walk decoder
// Loads code trees into the node table, moves the root register and streams
// compressed bytes. A behavioral copy of the table and walk position works
// out the symbols each accepted byte must give; every output beat is checked
// against the oldest symbol still due. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_huffman_tree_walk_decoder;
  import htw_pkg::*;

  localparam int NODE_COUNT   = 512;
  localparam int TREE_MAX     = 32;     // slots for one random tree (<= 23 used)
  localparam int DRAIN_CYCLES = 64;     // outlasts 3 decode beats in flight
  // A typical run: ~330 beats, each with an idle wait, its engine walk and up to 8 symbols
  // under random stalls, plus a drain per root write.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_CAP    = 40;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_t              in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_t             out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [IDX_W-1:0] cfg_data_i;

  huffman_tree_walk_decoder #(
    .NODE_COUNT(NODE_COUNT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Decoder state as the bench sees it. The node table starts unknown; the
  // stimulus keeps every interior node's children written, so a walk from
  // the root never touches an entry that was never loaded.
  // --------------------------------------------------------------------------
  node_t            node_mem     [NODE_COUNT];
  bit               node_written [NODE_COUNT];
  bit               tree_member  [NODE_COUNT];   // nodes of the tree in use
  logic [IDX_W-1:0] written_list [$];
  logic [IDX_W-1:0] root_reg;
  logic [IDX_W-1:0] walk_pos;
  out_t             symbols_due  [$];            // decoded symbols not yet seen

  int mismatch_count;
  int cycle_count;
  bit steady;                                    // no idling on either side

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP)
      $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Update the model for one accepted beat: a load writes the table, a decode works out its symbols and queues them.
  function automatic void decode_predict(input in_t beat);
    out_t pend;
    bit   have;
    have = 1'b0;
    if (beat.req_type == CMD_LOAD) begin
      node_mem[beat.node_index] = '{left:   beat.left_child,
                                    right:  beat.right_child,
                                    leaf:   beat.is_leaf,
                                    symbol: beat.leaf_symbol};
      if (!node_written[beat.node_index]) begin
        node_written[beat.node_index] = 1'b1;
        written_list.push_back(beat.node_index);
      end
      return;
    end
    // A leaf at the root: one error beat, no bits consumed.
    if (node_mem[root_reg].leaf) begin
      walk_pos = root_reg;
      symbols_due.push_back('{symbol: '0, last: 1'b1, error: 1'b1});
      return;
    end
    for (int k = TOP_BIT; k >= 0; k--) begin
      walk_pos = beat.code_byte[k] ? node_mem[walk_pos].right : node_mem[walk_pos].left;
      if (node_mem[walk_pos].leaf) begin
        if (have) symbols_due.push_back(pend);
        pend = '{symbol: node_mem[walk_pos].symbol, last: 1'b0, error: 1'b0};
        have = 1'b1;
        walk_pos = root_reg;
      end
    end
    // Only the final symbol of the byte carries last; a partial code is kept.
    if (have) begin
      pend.last = 1'b1;
      symbols_due.push_back(pend);
    end
  endfunction

  // Output side: check every accepted beat against the oldest symbol due.
  always @(posedge clk_i) begin : check_symbols
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (symbols_due.size() == 0) begin
        report_mismatch("symbol beat with none due", out_data_o, 0);
      end else begin
        want = symbols_due.pop_front();
        if (out_data_o.symbol !== want.symbol)
          report_mismatch("symbol", out_data_o.symbol, want.symbol);
        if (out_data_o.last !== want.last)
          report_mismatch("last", out_data_o.last, want.last);
        if (out_data_o.error !== want.error)
          report_mismatch("error", out_data_o.error, want.error);
      end
    end
  end

  // Receiver back-pressure: ready drops with a chance of about 31 in a hundred.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && (steady || $urandom_range(0, 99) >= 31);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("huffman_tree_walk_decoder: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Beat builders. Fields a beat does not use get random values.
  // --------------------------------------------------------------------------
  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom_range(0, NODE_COUNT - 1));
  endfunction

  function automatic logic [SYM_W-1:0] any_symbol();
    return SYM_W'($urandom_range(0, 255));
  endfunction

  function automatic in_t load_beat(input logic [IDX_W-1:0] idx,
                                    input logic [IDX_W-1:0] left,
                                    input logic [IDX_W-1:0] right,
                                    input logic leaf, input logic [SYM_W-1:0] sym);
    in_t beat;
    beat.req_type    = CMD_LOAD;
    beat.node_index  = idx;
    beat.left_child  = left;
    beat.right_child = right;
    beat.is_leaf     = leaf;
    beat.leaf_symbol = sym;
    beat.code_byte   = BYTE_W'($urandom_range(0, 255));
    return beat;
  endfunction

  function automatic in_t decode_beat(input logic [BYTE_W-1:0] code);
    in_t beat;
    beat.req_type    = CMD_DECODE;
    beat.node_index  = any_index();
    beat.left_child  = any_index();
    beat.right_child = any_index();
    beat.is_leaf     = 1'($urandom_range(0, 1));
    beat.leaf_symbol = any_symbol();
    beat.code_byte   = code;
    return beat;
  endfunction

  // A load that rewrites a node but keeps the live tree walkable: tree nodes
  // keep their kind (and interior ones their children), other interior nodes
  // only point at nodes already loaded.
  function automatic in_t overwrite_load();
    logic [IDX_W-1:0] idx;
    idx = any_index();
    if (tree_member[idx]) begin
      if (node_mem[idx].leaf)
        return load_beat(idx, any_index(), any_index(), 1'b1, any_symbol());
      return load_beat(idx, node_mem[idx].left, node_mem[idx].right, 1'b0, any_symbol());
    end
    if ($urandom_range(0, 1))
      return load_beat(idx, any_index(), any_index(), 1'b1, any_symbol());
    return load_beat(idx, written_list[$urandom_range(0, written_list.size() - 1)],
                     written_list[$urandom_range(0, written_list.size() - 1)],
                     1'b0, any_symbol());
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers. Every task starts and ends at a falling edge.
  // --------------------------------------------------------------------------
  task automatic send_beat(input in_t beat);
    if (!steady && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_data_i  <= beat;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    decode_predict(beat);
    @(negedge clk_i);
  endtask

  // Sender holds off until every symbol due has come out.
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (symbols_due.size() != 0);
  endtask

  // Beyond the last symbol, bytes that give none may still be in the engine.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (symbols_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_root(input logic [IDX_W-1:0] root);
    wait_idle();
    cfg_data_i  <= root;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    root_reg = root;
    walk_pos = root;                             // a root write restarts the walk
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Grows a random full binary tree by splitting leaves, scatters it over the
  // table and loads it. A comb-shaped tree gives codes longer than a byte.
  task automatic load_random_tree(input int leaf_total, input bit comb, input int fixed_root,
                                  output logic [IDX_W-1:0] root_id,
                                  output logic [IDX_W-1:0] leaf_id);
    int               kid_l    [TREE_MAX];
    int               kid_r    [TREE_MAX];
    bit               is_lf    [TREE_MAX];
    logic [IDX_W-1:0] slot_idx [TREE_MAX];
    int               open_leaves [$];
    int               used;
    int               pick;
    int               p;
    logic [IDX_W-1:0] idx;
    used     = 1;
    is_lf[0] = 1'b1;
    open_leaves.push_back(0);
    for (int k = 1; k < leaf_total; k++) begin
      pick = comb ? open_leaves.size() - 1 : $urandom_range(0, open_leaves.size() - 1);
      p    = open_leaves[pick];
      open_leaves.delete(pick);
      is_lf[p]      = 1'b0;
      kid_l[p]      = used;
      kid_r[p]      = used + 1;
      is_lf[used]   = 1'b1;
      is_lf[used+1] = 1'b1;
      if ($urandom_range(0, 1)) begin
        open_leaves.push_back(used);
        open_leaves.push_back(used + 1);
      end else begin
        open_leaves.push_back(used + 1);
        open_leaves.push_back(used);
      end
      used += 2;
    end
    tree_member = '{default: 1'b0};
    for (int s = 0; s < used; s++) begin
      if (s == 0 && fixed_root >= 0) idx = IDX_W'(fixed_root);
      else do idx = any_index(); while (tree_member[idx]);
      tree_member[idx] = 1'b1;
      slot_idx[s]      = idx;
    end
    for (int s = used - 1; s >= 0; s--) begin
      if (is_lf[s])
        send_beat(load_beat(slot_idx[s], any_index(), any_index(), 1'b1, any_symbol()));
      else
        send_beat(load_beat(slot_idx[s], slot_idx[kid_l[s]], slot_idx[kid_r[s]], 1'b0,
                            any_symbol()));
    end
    root_id = slot_idx[0];
    leaf_id = slot_idx[open_leaves[0]];
  endtask

  // One setting: fresh tree, new root, then random bytes with stray loads.
  task automatic run_phase(input int fixed_root, input bit root_on_leaf,
                           input int decode_total, input bit pause_mid);
    logic [IDX_W-1:0] root_id;
    logic [IDX_W-1:0] leaf_id;
    load_random_tree($urandom_range(2, 12), $urandom_range(0, 3) == 0, fixed_root,
                     root_id, leaf_id);
    write_root(root_on_leaf ? leaf_id : root_id);
    for (int k = 0; k < decode_total; k++) begin
      if (pause_mid && k == decode_total / 2) pause_until_drained();
      if ($urandom_range(0, 99) < 10) send_beat(overwrite_load());
      send_beat(decode_beat(BYTE_W'($urandom_range(0, 255))));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Root register still at node 0 after reset; make node 0 a leaf.
  task automatic test_root_leaf();
    send_beat(load_beat(9'd0, 9'd511, 9'd0, 1'b1, 8'hFF));
    send_beat(decode_beat(8'h00));
    send_beat(decode_beat(8'hFF));
  endtask

  // Fixed code: 0 -> 00, 10 -> FF, 11 1* 0 -> 5A. Node 510 loops on itself,
  // so a run of ones leaves a partial code that crosses byte boundaries.
  task automatic test_code_tree();
    send_beat(load_beat(9'd511, 9'd256, 9'd300, 1'b0, 8'h00));
    send_beat(load_beat(9'd256, 9'd511, 9'd0,   1'b1, 8'h00));
    send_beat(load_beat(9'd300, 9'd1,   9'd510, 1'b0, 8'hFF));
    send_beat(load_beat(9'd1,   9'd0,   9'd511, 1'b1, 8'hFF));
    send_beat(load_beat(9'd510, 9'd509, 9'd510, 1'b0, 8'h00));
    send_beat(load_beat(9'd509, 9'd0,   9'd0,   1'b1, 8'h5A));
    write_root(9'd511);
    send_beat(decode_beat(8'h00));               // eight symbols
    send_beat(decode_beat(8'hAA));               // four symbols
    send_beat(decode_beat(8'hFF));               // none, walk parked at 510
    send_beat(decode_beat(8'h00));               // code finishes, then seven
    send_beat(decode_beat(8'hB7));               // ends mid-code
    send_beat(load_beat(9'd2, 9'd511, 9'd511, 1'b1, 8'h81));  // load mid-code
    send_beat(decode_beat(8'h40));
    send_beat(decode_beat(8'h01));               // leaves walk at node 300
    write_root(9'd511);                          // same root, walk restarts
    send_beat(decode_beat(8'h00));
  endtask

  // Several settings, root at both ends of the index range and on a leaf.
  task automatic test_random_trees();
    run_phase(0, 1'b0, $urandom_range(14, 20), 1'b0);
    run_phase(NODE_COUNT - 1, 1'b0, $urandom_range(14, 20), 1'b0);
    run_phase(-1, 1'b1, 6, 1'b0);
    repeat (4) run_phase(-1, $urandom_range(0, 9) == 0, $urandom_range(14, 20), 1'b0);
  endtask

  // Back-to-back beats with the receiver always ready.
  task automatic test_steady_stream();
    steady = 1'b1;
    run_phase(-1, 1'b0, 40, 1'b0);
    steady = 1'b0;
  endtask

  // Sender stops halfway until the output side has caught up.
  task automatic test_sender_pause();
    run_phase(-1, 1'b0, 24, 1'b1);
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    steady         = 1'b0;
    root_reg       = '0;
    walk_pos       = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_root_leaf();
    test_code_tree();
    test_random_trees();
    test_steady_stream();
    test_sender_pause();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("huffman_tree_walk_decoder: match");
    end else begin
      $display("huffman_tree_walk_decoder: mismatch");
    end
    $finish;
  end

endmodule
